// File: hw/rtl/slu_pkg.sv
`timescale 1ns / 1ps
package slu_pkg;
    localparam int ENERGY_W = 40;
    localparam int TOL_W    = 16;
    localparam int FUNC_W   = 2;
    localparam int LIDX_W   = 3;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic                found;
        logic [ENERGY_W-1:0] best;
    } t_token;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                clear;
        logic                advance;
        logic [ENERGY_W-1:0] best;
        logic [TOL_W-1:0]    tol;
    } t_cell_cmd;
endpackage

// File: hw/rtl/sorted_list_union_merge.sv
`timescale 1ns / 1ps
// Union-grid merge of NUM_LISTS ascending lists held in a chain of cells, one
// list and its own RAM per cell. A load or clear is taken only while idle and
// busy does not rise. A request holds busy high through the states ST_PREF,
// which reads the list heads, ST_SCAN, in which the running minimum passes
// down the chain, and ST_ADV, which advances matching heads; the result is
// shown for one cycle on o_result_strobe after that and must be taken then,
// as the block has no way to hold it.
module sorted_list_union_merge #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [slu_pkg::FUNC_W-1:0]    i_func,
    input  logic [slu_pkg::LIDX_W-1:0]    i_list_index,
    input  logic [slu_pkg::ENERGY_W-1:0]  i_energy,
    input  logic                          i_cfg_we,
    input  logic [slu_pkg::TOL_W-1:0]     i_cfg_wdata,
    output logic                          o_result_strobe,
    output logic [slu_pkg::ENERGY_W-1:0]  o_grid_point,
    output logic                          o_point_valid,
    output logic                          o_merge_done
);
    import slu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREF = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_ADV  = 2'd3;
    localparam int CW = $clog2(NUM_LISTS + 1);

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [TOL_W-1:0]    r_tol;
    logic                r_stb;
    logic [ENERGY_W-1:0] r_point;
    logic                r_valid, r_done;
    logic                accept;
    logic                finish;
    t_cell_cmd           cmd;
    t_token              tok [NUM_LISTS+1];

    assign accept = start && !busy;
    assign busy   = r_state != ST_IDLE;
    assign finish = !tok[NUM_LISTS].found || tok[NUM_LISTS].best == '0;

    assign tok[0] = '{found: 1'b0, best: '0};

    always_comb begin
        cmd.clear   = accept && i_func == FUNC_CLEAR;
        cmd.advance = r_state == ST_ADV && !finish;
        cmd.best    = tok[NUM_LISTS].best;
        cmd.tol     = r_tol;
    end

    for (genvar k = 0; k < NUM_LISTS; k++) begin : g_cell
        slu_cell #(.LIST_DEPTH(LIST_DEPTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (accept && i_func == FUNC_LOAD && 32'(i_list_index) == k),
            .i_energy(i_energy),
            .i_cmd   (cmd),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1])
        );
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: if (accept && i_func == FUNC_REQUEST) begin
                n_state = ST_PREF;
            end
            ST_PREF: begin
                n_state = ST_SCAN;
                n_cnt   = '0;
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_LISTS - 1)) begin
                    n_state = ST_ADV;
                end
            end
            ST_ADV:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_tol   <= TOL_W'(1);
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stb   <= r_state == ST_ADV;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
        if (r_state == ST_ADV) begin
            r_point <= finish ? '0 : tok[NUM_LISTS].best;
            r_valid <= !finish;
            r_done  <= finish;
        end
    end

    assign o_result_strobe = r_stb;
    assign o_grid_point    = r_point;
    assign o_point_valid   = r_valid;
    assign o_merge_done    = r_done;

    // result transfer only right after the advance cycle
    a_stb_after_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state) == ST_ADV)
        else $error("result strobe without advance cycle");
    a_valid_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_point_valid != o_merge_done))
        else $error("point_valid and merge_done not exclusive");
    a_zero_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_merge_done) |-> o_grid_point == '0)
        else $error("grid point not zero on done");
    a_busy_on_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_REQUEST) |=> busy)
        else $error("request did not raise busy");
endmodule

// File: hw/rtl/slu_ram.sv
`timescale 1ns / 1ps
module slu_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/slu_cell.sv
`timescale 1ns / 1ps
module slu_cell #(
    parameter int LIST_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [slu_pkg::ENERGY_W-1:0]        i_energy,
    input  slu_pkg::t_cell_cmd                  i_cmd,
    input  slu_pkg::t_token                     i_tok,
    output slu_pkg::t_token                     o_tok
);
    import slu_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam logic [LW-1:0] FULL = LW'(LIST_DEPTH);

    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_head, n_head;
    t_token              r_tok, n_tok;
    logic [ENERGY_W-1:0] head_val;
    logic [ENERGY_W-1:0] diff;
    logic                active;
    logic                near;

    slu_ram #(.WIDTH(ENERGY_W), .DEPTH(LIST_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_load && (r_len < FULL)),
        .i_waddr(r_len[AW-1:0]),
        .i_wdata(i_energy),
        .i_raddr(r_head[AW-1:0]),
        .o_rdata(head_val)
    );

    assign active = r_head < r_len;
    assign diff   = (head_val > i_cmd.best) ? head_val - i_cmd.best : i_cmd.best - head_val;
    assign near   = diff <= ENERGY_W'(i_cmd.tol);

    always_comb begin
        n_len  = r_len;
        n_head = r_head;
        n_tok  = i_tok;
        if (active && (!i_tok.found || head_val < i_tok.best)) begin
            n_tok.found = 1'b1;
            n_tok.best  = head_val;
        end
        if (i_cmd.clear) begin
            n_len  = '0;
            n_head = '0;
        end else begin
            if (i_load && (r_len < FULL)) begin
                n_len = r_len + 1'b1;
            end
            if (i_cmd.advance && active && near) begin
                n_head = r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_head <= '0;
        end else begin
            r_len  <= n_len;
            r_head <= n_head;
        end
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;
endmodule
